/* design/pedsd_pkg.sv */
// ----------------------------------------------------------------------------
// pedsd_pkg
// shared types and constants of the pedometer step detector
// ----------------------------------------------------------------------------
`default_nettype none

package pedsd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALLEY_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PROM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAD_TOL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 3'd6;

    // register reset values
    localparam logic signed [15:0] PEAK_THR_RST   = 16'sd192;
    localparam logic signed [15:0] VALLEY_THR_RST = -16'sd90;
    localparam logic [15:0]        MIN_PROM_RST   = 16'd294;
    localparam logic [15:0]        MIN_IV_RST     = 16'd280;
    localparam logic [15:0]        MAX_IV_RST     = 16'd1300;
    localparam logic [7:0]         CAD_TOL_RST    = 8'd115;
    localparam logic [3:0]         CONFIRM_RST    = 4'd3;

    // filter levels: signed q16, samples stay below 2^24
    localparam int LVL_W       = 27;
    localparam int ALPHA_W     = 15;
    localparam int ALPHA_SHIFT = 16;
    localparam int PROD_W      = LVL_W + ALPHA_W;

    typedef logic signed [LVL_W-1:0]  t_lvl;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam logic [ALPHA_W-1:0] GRAVITY_ALPHA = 15'd1311;
    localparam logic [ALPHA_W-1:0] MOTION_ALPHA  = 15'd22938;

    // shared iteration counter for the serial multiplier and divider
    localparam int CNT_W     = 4;
    localparam int DIV_STEPS = 16;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ALPHA_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic [15:0] CADENCE_NUM = 16'd60000;
    localparam logic [15:0] CADENCE_SAT = 16'hFFFF;
    localparam logic [3:0]  PEND_MAX    = 4'd15;

    typedef struct packed {
        logic [15:0] accel_magnitude;
        logic [31:0] sample_time;
        logic        sample_bad;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  step_count;
        logic [15:0] step_rate;
        logic        walking;
    } t_out_item;

endpackage

`default_nettype wire

/* design/pedsd_in_if.sv */
// ----------------------------------------------------------------------------
// pedsd_in_if
// sample channel: valid/ready handshake with an input item payload
// ----------------------------------------------------------------------------
`default_nettype none

interface pedsd_in_if;
    import pedsd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/pedsd_out_if.sv */
// ----------------------------------------------------------------------------
// pedsd_out_if
// result channel: valid/ready handshake with a result item payload
// ----------------------------------------------------------------------------
`default_nettype none

interface pedsd_out_if;
    import pedsd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/pedometer_step_detector.sv */
// ----------------------------------------------------------------------------
// pedometer_step_detector
// peak-detecting step counter on timestamped acceleration magnitudes
// ----------------------------------------------------------------------------
// One item in, one result item out. A bad sample or the first good sample
// (which seeds the gravity filter) goes straight from acceptance to the
// finish state. Every other sample runs the gravity and motion low-pass
// filters on one shift-and-add multiplier that consumes one alpha bit per
// cycle, then valley tracking, peak and interval checks and the step and
// timeout decisions, and, when a plausible, consistent and nonzero step
// interval was measured, a bit-serial restoring divider for 60000/interval.
// The sequencer takes the next item once the current one has been handed
// to the output register, which holds one finished result while the next
// item is processed. Configuration is written through i_cfg_we, i_cfg_idx
// and i_cfg_data; the user must write it only while no item is in flight,
// as the block itself does not enforce this. Timestamps wrap modulo 2^TIME_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module pedometer_step_detector #(
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pedsd_in_if.sink                          i_in,
    pedsd_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [pedsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pedsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pedsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GRAV,   // gravity filter, serial multiply
        S_MSET,   // load motion filter operand
        S_MOT,    // motion filter, serial multiply
        S_VAL,    // valley tracking and elapsed time
        S_PEAK,   // peak and interval checks
        S_ACT,    // apply step / timeout decisions
        S_DIV,    // serial cadence division
        S_FIN     // hand result to output register
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [15:0] r_peak_thr;
    logic signed [15:0] r_valley_thr;
    logic [15:0]        r_min_prom;
    logic [15:0]        r_min_iv;
    logic [15:0]        r_max_iv;
    logic [7:0]         r_tol;
    logic [3:0]         r_confirm;

    // detector state
    logic                 r_seeded;
    t_lvl                 r_grav;
    t_lvl                 r_motion;
    t_lvl                 r_prior;
    t_lvl                 r_valley;
    logic [TIME_BITS-1:0] r_cand;
    logic                 r_have;
    logic [15:0]          r_prior_iv;
    logic [3:0]           r_pending;
    logic                 r_walking;
    logic [15:0]          r_cadence;

    // per-item working registers
    t_lvl                 r_a;
    logic [TIME_BITS-1:0] r_ts;
    logic                 r_bad;
    logic [3:0]           r_steps;
    logic [TIME_BITS-1:0] r_elapsed;
    logic                 r_peak;
    logic                 r_take;
    logic                 r_timeout;

    // shared serial multiplier and divider
    t_prod              r_mcand;
    t_prod              r_acc;
    logic [ALPHA_W-1:0] r_mplier;
    logic [CNT_W-1:0]   r_cnt;
    logic [15:0]        r_div;
    logic [15:0]        r_rem;
    logic [15:0]        r_quo;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // combinational helpers
    t_lvl        w_a_in;
    t_prod       n_acc;
    t_lvl        w_step;
    t_lvl        w_peak_lvl;
    t_lvl        w_valley_lvl;
    t_lvl        w_prom_lvl;
    t_lvl        w_rise;
    logic        w_peak;
    logic        w_plaus;
    logic        w_iv_ok;
    logic        w_timeout;
    logic [15:0] w_iv;
    logic [15:0] w_diff;
    logic [3:0]  n_pending;
    logic [16:0] w_rem_sh;
    logic        w_ge;
    logic [15:0] n_rem;
    logic [15:0] n_quo;

    // sample in q16
    assign w_a_in = t_lvl'({i_in.payload.accel_magnitude, 8'h00});

    // one alpha bit per cycle; arithmetic shift floors the product
    assign n_acc  = r_acc + (r_mplier[0] ? r_mcand : t_prod'(0));
    assign w_step = t_lvl'(n_acc >>> ALPHA_SHIFT);

    // thresholds scaled from q8.8 to q16
    assign w_peak_lvl   = t_lvl'(r_peak_thr) <<< 8;
    assign w_valley_lvl = t_lvl'(r_valley_thr) <<< 8;
    assign w_prom_lvl   = t_lvl'({r_min_prom, 8'h00});
    assign w_rise       = r_prior - r_valley;

    assign w_peak = (r_prior > r_motion) && (r_prior >= w_peak_lvl)
                 && (r_valley <= w_valley_lvl) && (w_rise >= w_prom_lvl);

    // interval checks; the low bits are the interval whenever it is plausible
    assign w_iv    = r_elapsed[15:0];
    assign w_plaus = (r_elapsed >= TIME_BITS'(r_min_iv))
                  && (r_elapsed <= TIME_BITS'(r_max_iv));
    assign w_diff  = (w_iv >= r_prior_iv) ? (w_iv - r_prior_iv) : (r_prior_iv - w_iv);
    assign w_iv_ok = (r_prior_iv == 16'd0)
                  || ({w_diff, 8'h00} <= (24'(r_prior_iv) * 24'(r_tol)));
    assign w_timeout = r_elapsed > TIME_BITS'(r_max_iv);

    // pending count saturates
    assign n_pending = (r_pending == PEND_MAX) ? r_pending : (r_pending + 4'd1);

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_quo[15]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign n_rem    = w_ge ? 16'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[15:0];
    assign n_quo    = {r_quo[14:0], w_ge};

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_peak_thr   <= PEAK_THR_RST;
            r_valley_thr <= VALLEY_THR_RST;
            r_min_prom   <= MIN_PROM_RST;
            r_min_iv     <= MIN_IV_RST;
            r_max_iv     <= MAX_IV_RST;
            r_tol        <= CAD_TOL_RST;
            r_confirm    <= CONFIRM_RST;
            r_seeded     <= 1'b0;
            r_grav       <= '0;
            r_motion     <= '0;
            r_prior      <= '0;
            r_valley     <= '0;
            r_cand       <= '0;
            r_have       <= 1'b0;
            r_prior_iv   <= '0;
            r_pending    <= '0;
            r_walking    <= 1'b0;
            r_cadence    <= '0;
            r_bad        <= 1'b0;
            r_steps      <= '0;
            r_cnt        <= '0;
        end else begin
            // result register: filled from the finish state, emptied by the sink
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PEAK_THR:   r_peak_thr   <= i_cfg_data;
                    CFG_VALLEY_THR: r_valley_thr <= i_cfg_data;
                    CFG_MIN_PROM:   r_min_prom   <= i_cfg_data;
                    CFG_MIN_IV:     r_min_iv     <= i_cfg_data;
                    CFG_MAX_IV:     r_max_iv     <= i_cfg_data;
                    CFG_CAD_TOL:    r_tol        <= i_cfg_data[7:0];
                    CFG_CONFIRM:    r_confirm    <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_a     <= w_a_in;
                        r_ts    <= TIME_BITS'(i_in.payload.sample_time);
                        r_bad   <= i_in.payload.sample_bad;
                        r_steps <= '0;
                        if (i_in.payload.sample_bad) begin
                            r_state <= S_FIN;
                        end else if (!r_seeded) begin
                            // first good sample only seeds gravity
                            r_seeded <= 1'b1;
                            r_grav   <= w_a_in;
                            r_state  <= S_FIN;
                        end else begin
                            r_mcand  <= t_prod'(w_a_in - r_grav);
                            r_mplier <= GRAVITY_ALPHA;
                            r_acc    <= '0;
                            r_cnt    <= '0;
                            r_state  <= S_GRAV;
                        end
                    end
                end

                S_GRAV: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_grav  <= r_grav + w_step;
                        r_state <= S_MSET;
                    end
                end

                S_MSET: begin
                    // linear acceleration minus current motion level
                    r_mcand  <= t_prod'(r_a - r_grav - r_motion);
                    r_mplier <= MOTION_ALPHA;
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_state  <= S_MOT;
                end

                S_MOT: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_motion <= r_motion + w_step;
                        r_state  <= S_VAL;
                    end
                end

                S_VAL: begin
                    if (r_motion < r_valley) begin
                        r_valley <= r_motion;
                    end
                    r_elapsed <= r_ts - r_cand;
                    r_state   <= S_PEAK;
                end

                S_PEAK: begin
                    r_peak    <= w_peak;
                    r_take    <= r_have && w_plaus && w_iv_ok;
                    r_timeout <= r_have && w_timeout;
                    r_state   <= S_ACT;
                end

                S_ACT: begin
                    r_prior <= r_motion;
                    r_state <= S_FIN;
                    if (r_peak) begin
                        r_cand   <= r_ts;
                        r_have   <= 1'b1;
                        r_valley <= r_motion;
                        if (!r_take) begin
                            // inconsistent candidate restarts the count
                            r_walking  <= 1'b0;
                            r_cadence  <= '0;
                            r_pending  <= 4'd1;
                            r_prior_iv <= '0;
                        end else begin
                            r_prior_iv <= w_iv;
                            if (w_iv == 16'd0) begin
                                r_cadence <= CADENCE_SAT;
                            end else begin
                                r_div   <= w_iv;
                                r_rem   <= '0;
                                r_quo   <= CADENCE_NUM;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end
                            if (r_walking) begin
                                r_steps <= 4'd1;
                            end else if (n_pending >= r_confirm) begin
                                r_walking <= 1'b1;
                                r_steps   <= n_pending;
                                r_pending <= '0;
                            end else begin
                                r_pending <= n_pending;
                            end
                        end
                    end else if (r_timeout) begin
                        // no candidate within the longest interval
                        r_walking  <= 1'b0;
                        r_cadence  <= '0;
                        r_pending  <= '0;
                        r_prior_iv <= '0;
                    end
                end

                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_cadence <= n_quo;
                        r_state   <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out.step_count <= r_steps;
                        r_out.step_rate  <= r_bad ? 16'd0 : r_cadence;
                        r_out.walking    <= r_bad ? 1'b0 : r_walking;
                        r_state          <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/pedsd_checker.sv */
// ----------------------------------------------------------------------------
// pedsd_checker
// port-level checks of the pedometer step detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pedsd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input pedsd_pkg::t_out_item i_out_payload
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // steps are only reported while walking
    a_steps_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_payload.step_count != 4'd0) |-> i_out_payload.walking)
        else $error("steps reported while not walking");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind pedometer_step_detector pedsd_checker u_pedsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire
